// ===== hdl/force_admittance_velocity_top_defines.svh =====
// ----------------------------------------------------------------------------
// force_admittance_velocity_top_defines: assertion macros
// Shared property shapes for the block's port checker.
// ----------------------------------------------------------------------------
`ifndef FORCE_ADMITTANCE_VELOCITY_TOP_DEFINES_SVH
`define FORCE_ADMITTANCE_VELOCITY_TOP_DEFINES_SVH

// implication into the next cycle, masked while reset is high
`define FAV_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fav checker: property failed");

// what must hold in the cycle after reset
`define FAV_ASSERT_RST(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("fav checker: reset property failed");

`endif

// ===== hdl/fav_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fav_pkg
// Types, widths and helpers shared by the force admittance velocity block.
// ----------------------------------------------------------------------------
package fav_pkg;

   localparam int FIELD_W = 16;
   localparam int ROW_W   = 48;
   localparam int SUM_W   = 21;
   localparam int OUT_W   = 24;
   localparam int GAIN_W  = 12;
   localparam int DB_W    = 15;
   localparam int DVD_W   = 28;
   localparam int ADDR_W  = 2;

   localparam logic [ADDR_W-1:0] CSR_FORCE_GAIN  = 2'd0;
   localparam logic [ADDR_W-1:0] CSR_TORQUE_GAIN = 2'd1;
   localparam logic [ADDR_W-1:0] CSR_FORCE_DB    = 2'd2;
   localparam logic [ADDR_W-1:0] CSR_TORQUE_DB   = 2'd3;

   typedef struct packed {
      logic [GAIN_W-1:0] force_gain;
      logic [GAIN_W-1:0] torque_gain;
      logic [DB_W-1:0]   force_db;
      logic [DB_W-1:0]   torque_db;
   } cfg_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum_fx;
      logic signed [SUM_W-1:0] sum_fy;
      logic signed [SUM_W-1:0] sum_fz;
      logic signed [SUM_W-1:0] sum_tz;
      logic [ROW_W-1:0]        row_x;
      logic [ROW_W-1:0]        row_y;
      logic [ROW_W-1:0]        row_z;
   } job_type;

   // signed saturation of a quotient magnitude to the output width
   function automatic logic [OUT_W-1:0] sat_out(input logic [DVD_W-1:0] q, input logic neg);
      logic [OUT_W-1:0] r;
      if (!neg) begin
         if (q > DVD_W'(24'h7FFFFF)) r = 24'h7FFFFF;
         else r = q[OUT_W-1:0];
      end else begin
         if (q > DVD_W'(24'h800000)) r = 24'h800000;
         else r = ~q[OUT_W-1:0] + 24'd1;
      end
      return r;
   endfunction

endpackage

// ===== hdl/fav_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fav_req_if / fav_rsp_if
// Valid/ready channels for samples and for velocity results.
// ----------------------------------------------------------------------------
interface fav_req_if;
   logic                valid;
   logic                ready;
   logic signed [15:0]  sample_fx;
   logic signed [15:0]  sample_fy;
   logic signed [15:0]  sample_fz;
   logic signed [15:0]  sample_tz;
   logic [47:0]         rot_row_x;
   logic [47:0]         rot_row_y;
   logic [47:0]         rot_row_z;
   modport source (output valid, sample_fx, sample_fy, sample_fz, sample_tz,
                   rot_row_x, rot_row_y, rot_row_z, input ready);
   modport sink   (input valid, sample_fx, sample_fy, sample_fz, sample_tz,
                   rot_row_x, rot_row_y, rot_row_z, output ready);
endinterface

interface fav_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [23:0]  vel_x;
   logic signed [23:0]  vel_y;
   logic signed [23:0]  vel_z;
   logic signed [23:0]  spin_z;
   modport source (output valid, vel_x, vel_y, vel_z, spin_z, input ready);
   modport sink   (input valid, vel_x, vel_y, vel_z, spin_z, output ready);
endinterface

// ===== hdl/fav_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fav_queue
// Two-entry job queue between the window front and the math back.
// ----------------------------------------------------------------------------
module fav_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fav_pkg::job_type push_data,
   output logic             has_room,
   input  logic             pop,
   output logic             pop_valid,
   output fav_pkg::job_type pop_data
);
   fav_pkg::job_type slot_ff [2];
   logic             wptr_ff;
   logic             rptr_ff;
   logic [1:0]       count_ff;

   assign has_room  = (count_ff < 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop) rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ===== hdl/fav_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fav_front
// Takes sample beats, keeps the sliding window and running sums, and queues
// a job for every sample once the window is full.
// ----------------------------------------------------------------------------
module fav_front #(
   parameter int WINDOW_LEN = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   fav_req_if.sink              req_bus,
   input  logic                 q_room,
   output logic                 q_push,
   output fav_pkg::job_type     q_data
);
   localparam int SLOT_W = $clog2(WINDOW_LEN);
   localparam int FILL_W = $clog2(WINDOW_LEN + 1);

   logic [47:0] force_mem [WINDOW_LEN];
   logic [15:0] torque_mem [WINDOW_LEN];

   logic                       upd_ff;
   logic [SLOT_W-1:0]          slot_ff;
   logic [FILL_W-1:0]          fill_ff;
   logic [47:0]                old_f_ff;
   logic [15:0]                old_t_ff;
   logic signed [15:0]         new_fx_ff, new_fy_ff, new_fz_ff, new_tz_ff;
   logic [47:0]                row_x_ff, row_y_ff, row_z_ff;
   logic signed [fav_pkg::SUM_W-1:0] sum_fx_ff, sum_fy_ff, sum_fz_ff, sum_tz_ff;
   logic signed [fav_pkg::SUM_W-1:0] sum_fx_in, sum_fy_in, sum_fz_in, sum_tz_in;
   logic                       full;
   logic                       accept;

   assign req_bus.ready = !upd_ff && q_room;
   assign accept        = req_bus.valid && req_bus.ready;
   assign full          = (fill_ff == FILL_W'(WINDOW_LEN));

   // window memory: old entry read out while the new one goes in
   always_ff @(posedge clock) begin
      if (accept) begin
         force_mem[slot_ff]  <= {req_bus.sample_fz, req_bus.sample_fy, req_bus.sample_fx};
         torque_mem[slot_ff] <= req_bus.sample_tz;
         old_f_ff            <= force_mem[slot_ff];
         old_t_ff            <= torque_mem[slot_ff];
         new_fx_ff           <= req_bus.sample_fx;
         new_fy_ff           <= req_bus.sample_fy;
         new_fz_ff           <= req_bus.sample_fz;
         new_tz_ff           <= req_bus.sample_tz;
         row_x_ff            <= req_bus.rot_row_x;
         row_y_ff            <= req_bus.rot_row_y;
         row_z_ff            <= req_bus.rot_row_z;
      end
   end

   always_comb begin
      sum_fx_in = sum_fx_ff + fav_pkg::SUM_W'(new_fx_ff);
      sum_fy_in = sum_fy_ff + fav_pkg::SUM_W'(new_fy_ff);
      sum_fz_in = sum_fz_ff + fav_pkg::SUM_W'(new_fz_ff);
      sum_tz_in = sum_tz_ff + fav_pkg::SUM_W'(new_tz_ff);
      if (full) begin
         sum_fx_in = sum_fx_in - fav_pkg::SUM_W'($signed(old_f_ff[15:0]));
         sum_fy_in = sum_fy_in - fav_pkg::SUM_W'($signed(old_f_ff[31:16]));
         sum_fz_in = sum_fz_in - fav_pkg::SUM_W'($signed(old_f_ff[47:32]));
         sum_tz_in = sum_tz_in - fav_pkg::SUM_W'($signed(old_t_ff));
      end
   end

   assign q_push        = upd_ff && full;
   assign q_data.sum_fx = sum_fx_in;
   assign q_data.sum_fy = sum_fy_in;
   assign q_data.sum_fz = sum_fz_in;
   assign q_data.sum_tz = sum_tz_in;
   assign q_data.row_x  = row_x_ff;
   assign q_data.row_y  = row_y_ff;
   assign q_data.row_z  = row_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_ff    <= 1'b0;
         slot_ff   <= '0;
         fill_ff   <= '0;
         sum_fx_ff <= '0;
         sum_fy_ff <= '0;
         sum_fz_ff <= '0;
         sum_tz_ff <= '0;
      end else begin
         upd_ff <= accept;
         if (upd_ff) begin
            sum_fx_ff <= sum_fx_in;
            sum_fy_ff <= sum_fy_in;
            sum_fz_ff <= sum_fz_in;
            sum_tz_ff <= sum_tz_in;
            if (!full) fill_ff <= fill_ff + FILL_W'(1);
            if (slot_ff == SLOT_W'(WINDOW_LEN - 1)) slot_ff <= '0;
            else slot_ff <= slot_ff + SLOT_W'(1);
         end
      end
   end
endmodule

// ===== hdl/fav_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fav_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fav_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fav_pkg::DVD_W-1:0]    dividend,
   input  logic [fav_pkg::GAIN_W-1:0]   divisor,
   output logic                         done,
   output logic [fav_pkg::DVD_W-1:0]    quotient
);
   localparam int CNT_W = $clog2(fav_pkg::DVD_W + 1);

   logic [fav_pkg::DVD_W-1:0]  quo_ff;
   logic [fav_pkg::GAIN_W-1:0] rem_ff;
   logic [fav_pkg::GAIN_W-1:0] dsr_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [fav_pkg::GAIN_W:0]   trial;
   logic                       fits;

   assign trial    = {rem_ff, quo_ff[fav_pkg::DVD_W-1]};
   assign fits     = (trial >= {1'b0, dsr_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[fav_pkg::DVD_W-2:0], fits};
         rem_ff <= fits ? fav_pkg::GAIN_W'(trial - {1'b0, dsr_ff})
                        : trial[fav_pkg::GAIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(fav_pkg::DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

// ===== hdl/fav_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fav_back
// Sequencer for one job: window means, rotation, deadband tests, gain
// divisions and the result register.
// ----------------------------------------------------------------------------
module fav_back #(
   parameter int WINDOW_LEN = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fav_pkg::cfg_type         cfg,
   input  logic                     q_valid,
   input  fav_pkg::job_type         q_data,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [fav_pkg::OUT_W-1:0] rsp_vel_x,
   output logic [fav_pkg::OUT_W-1:0] rsp_vel_y,
   output logic [fav_pkg::OUT_W-1:0] rsp_vel_z,
   output logic [fav_pkg::OUT_W-1:0] rsp_spin_z
);
   // reciprocal of the window length, exact for sum magnitudes up to 2^20
   localparam int RCP_SH = 26;
   localparam int PROD_W = fav_pkg::SUM_W + RCP_SH;
   localparam logic [RCP_SH-1:0] RCP_MUL =
      RCP_SH'(((64'd1 << RCP_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MEAN = 6'b000010,
      ST_ROT  = 6'b000100,
      ST_MAG  = 6'b001000,
      ST_VDIV = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type               state_ff;
   logic [1:0]              idx_ff, row_ff, col_ff;
   logic                    wait_ff;
   fav_pkg::job_type        job_ff;
   logic signed [15:0]      mean_ff [4];
   logic signed [34:0]      acc_ff;
   logic signed [18:0]      rv_ff [3];
   logic [39:0]             mag_ff;
   logic                    fpass_ff, tpass_ff;
   logic [fav_pkg::OUT_W-1:0] res_ff [4];
   logic                    rsp_valid_ff;
   logic [fav_pkg::OUT_W-1:0] out_ff [4];

   logic signed [fav_pkg::SUM_W-1:0] sum_sel;
   logic [fav_pkg::SUM_W-1:0]        sum_abs;
   logic [PROD_W-1:0]                mean_prod;
   logic [15:0]                      mean_quo;
   logic [fav_pkg::ROW_W-1:0]        row_sel;
   logic signed [15:0]               entry;
   logic signed [18:0]               mul_a, mul_b;
   logic signed [37:0]               prod;
   logic signed [34:0]               acc_sum;
   logic signed [18:0]               r_sel;
   logic [18:0]                      r_abs;
   logic [16:0]                      mtz_abs;
   logic [fav_pkg::GAIN_W-1:0]       alpha, beta;
   logic                             need;
   logic                             div_start, div_done, div_neg;
   logic [fav_pkg::DVD_W-1:0]        div_dvd, div_quo;
   logic [fav_pkg::GAIN_W-1:0]       div_dsr;

   always_comb begin
      case (idx_ff)
         2'd0:    sum_sel = job_ff.sum_fx;
         2'd1:    sum_sel = job_ff.sum_fy;
         2'd2:    sum_sel = job_ff.sum_fz;
         default: sum_sel = job_ff.sum_tz;
      endcase
      case (row_ff)
         2'd0:    row_sel = job_ff.row_x;
         2'd1:    row_sel = job_ff.row_y;
         default: row_sel = job_ff.row_z;
      endcase
      case (col_ff)
         2'd0:    entry = $signed(row_sel[15:0]);
         2'd1:    entry = $signed(row_sel[31:16]);
         default: entry = $signed(row_sel[47:32]);
      endcase
   end

   assign sum_abs   = sum_sel[fav_pkg::SUM_W-1] ? fav_pkg::SUM_W'(-sum_sel) : sum_sel;
   assign mean_prod = PROD_W'(sum_abs) * PROD_W'(RCP_MUL);
   assign mean_quo  = mean_prod[RCP_SH+15:RCP_SH];
   assign r_sel   = (idx_ff == 2'd3) ? 19'sd0 : rv_ff[idx_ff];
   assign r_abs   = r_sel[18] ? 19'(-r_sel) : r_sel;
   assign mtz_abs = mean_ff[3][15] ? 17'(-17'(mean_ff[3])) : 17'(mean_ff[3]);
   assign alpha   = (cfg.force_gain == '0) ? fav_pkg::GAIN_W'(1) : cfg.force_gain;
   assign beta    = (cfg.torque_gain == '0) ? fav_pkg::GAIN_W'(1) : cfg.torque_gain;
   assign need    = (idx_ff == 2'd3) ? tpass_ff : fpass_ff;

   // one shared multiplier: rotation terms, squares and the threshold square
   always_comb begin
      if (state_ff == ST_ROT) begin
         mul_a = 19'(entry);
         mul_b = 19'(mean_ff[col_ff]);
      end else if (idx_ff == 2'd3) begin
         mul_a = 19'({4'd0, cfg.force_db});
         mul_b = 19'({4'd0, cfg.force_db});
      end else begin
         mul_a = r_sel;
         mul_b = r_sel;
      end
   end
   assign prod    = mul_a * mul_b;
   assign acc_sum = acc_ff + 35'(prod);

   always_comb begin
      if (idx_ff == 2'd3) begin
         div_dvd = fav_pkg::DVD_W'({mtz_abs, 6'd0});
         div_dsr = beta;
         div_neg = !mean_ff[3][15];
      end else begin
         div_dvd = {r_abs[17:0], 10'd0};
         div_dsr = alpha;
         div_neg = r_sel[18];
      end
   end

   assign div_start = !wait_ff && (state_ff == ST_VDIV) && need;

   fav_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign q_pop = (state_ff == ST_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (q_pop) job_ff <= q_data;
      if (state_ff == ST_MEAN)
         mean_ff[idx_ff] <= sum_sel[fav_pkg::SUM_W-1] ? 16'(-mean_quo) : mean_quo;
      if (state_ff == ST_ROT && col_ff == 2'd2) rv_ff[row_ff] <= acc_sum[32:14];
      if (state_ff == ST_VDIV) begin
         if (!need) res_ff[idx_ff] <= '0;
         else if (wait_ff && div_done) res_ff[idx_ff] <= fav_pkg::sat_out(div_quo, div_neg);
      end
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
         out_ff[0] <= res_ff[0];
         out_ff[1] <= res_ff[1];
         out_ff[2] <= res_ff[2];
         out_ff[3] <= res_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= 2'd0;
         row_ff       <= 2'd0;
         col_ff       <= 2'd0;
         wait_ff      <= 1'b0;
         acc_ff       <= '0;
         mag_ff       <= '0;
         fpass_ff     <= 1'b0;
         tpass_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) rsp_valid_ff <= 1'b0;
         if (div_start) wait_ff <= 1'b1;
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  state_ff <= ST_MEAN;
                  idx_ff   <= 2'd0;
               end
            end
            ST_MEAN: begin
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_ff <= ST_ROT;
                  row_ff   <= 2'd0;
                  col_ff   <= 2'd0;
                  acc_ff   <= '0;
               end
            end
            ST_ROT: begin
               if (col_ff == 2'd2) begin
                  acc_ff <= '0;
                  col_ff <= 2'd0;
                  row_ff <= row_ff + 2'd1;
                  if (row_ff == 2'd2) begin
                     state_ff <= ST_MAG;
                     idx_ff   <= 2'd0;
                     mag_ff   <= '0;
                  end
               end else begin
                  acc_ff <= acc_sum;
                  col_ff <= col_ff + 2'd1;
               end
            end
            ST_MAG: begin
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  fpass_ff <= (mag_ff > 40'(prod[29:0]));
                  tpass_ff <= (mtz_abs > 17'(cfg.torque_db));
                  state_ff <= ST_VDIV;
               end else begin
                  mag_ff <= mag_ff + 40'(prod[37:0]);
               end
            end
            ST_VDIV: begin
               if (!need || (wait_ff && div_done)) begin
                  wait_ff <= 1'b0;
                  idx_ff  <= idx_ff + 2'd1;
                  if (idx_ff == 2'd3) state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vel_x  = out_ff[0];
   assign rsp_vel_y  = out_ff[1];
   assign rsp_vel_z  = out_ff[2];
   assign rsp_spin_z = out_ff[3];
endmodule

// ===== hdl/force_admittance_velocity_top.sv =====
// sequence: the back runs the means, rotation and deadband tests, then a gain division for each
//   force axis when the force passes and for the spin when the torque passes
// flow: the back handles one job at a time, with up to four gain divisions on the shared
//   1-bit-per-cycle divider; the front takes no beat while it updates the sums for the last
//   one, nor while the 2-entry queue is full
// reset: synchronous, clears window fill, running sums, queue and sequencer
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// force_admittance_velocity_top
// Sliding-window admittance control with force and torque deadbands.
// ----------------------------------------------------------------------------
module force_admittance_velocity_top #(
   parameter int WINDOW_LEN = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   fav_req_if.sink                     req_bus,
   fav_rsp_if.source                   rsp_bus,
   input  logic                        csr_we,
   input  logic [fav_pkg::ADDR_W-1:0]  csr_addr,
   input  logic [fav_pkg::DB_W-1:0]    csr_wdata
);
   fav_pkg::cfg_type cfg_ff;
   logic             q_room, q_push, q_pop, q_valid;
   fav_pkg::job_type q_in, q_out;
   logic [fav_pkg::OUT_W-1:0] vx, vy, vz, sz;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.force_gain  <= 12'd175;
         cfg_ff.torque_gain <= 12'd3;
         cfg_ff.force_db    <= 15'd320;
         cfg_ff.torque_db   <= 15'd102;
      end else if (csr_we) begin
         case (csr_addr)
            fav_pkg::CSR_FORCE_GAIN:  cfg_ff.force_gain  <= csr_wdata[fav_pkg::GAIN_W-1:0];
            fav_pkg::CSR_TORQUE_GAIN: cfg_ff.torque_gain <= csr_wdata[fav_pkg::GAIN_W-1:0];
            fav_pkg::CSR_FORCE_DB:    cfg_ff.force_db    <= csr_wdata;
            fav_pkg::CSR_TORQUE_DB:   cfg_ff.torque_db   <= csr_wdata;
            default: ;
         endcase
      end
   end

   fav_front #(.WINDOW_LEN(WINDOW_LEN)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_room  (q_room),
      .q_push  (q_push),
      .q_data  (q_in)
   );

   fav_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .has_room  (q_room),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_out)
   );

   fav_back #(.WINDOW_LEN(WINDOW_LEN)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_data     (q_out),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_vel_x  (vx),
      .rsp_vel_y  (vy),
      .rsp_vel_z  (vz),
      .rsp_spin_z (sz)
   );

   assign rsp_bus.vel_x  = vx;
   assign rsp_bus.vel_y  = vy;
   assign rsp_bus.vel_z  = vz;
   assign rsp_bus.spin_z = sz;
endmodule

// ===== hdl/fav_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fav_checker
// Port-level properties of the force admittance velocity block.
// ----------------------------------------------------------------------------
`include "force_admittance_velocity_top_defines.svh"

module fav_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_vel_x,
   input logic [23:0] rsp_spin_z
);
   `FAV_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `FAV_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_vel_x) && $stable(rsp_spin_z))
   `FAV_ASSERT_RST(a_rst_idle, !rsp_valid && req_ready)
   // the front updates its sums in the cycle after every beat and takes no beat then
   `FAV_ASSERT_NEXT(a_front_busy, req_valid && req_ready, !req_ready)
endmodule

bind force_admittance_velocity_top fav_checker u_fav_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_vel_x  (rsp_bus.vel_x),
   .rsp_spin_z (rsp_bus.spin_z)
);

// ===== dv/force_admittance_velocity_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// force_admittance_velocity_top_test
// Drives force/torque samples with rotations through the admittance block
// under several gain and deadband settings, with random gaps and stalls.
// Each result beat is checked against an in-bench window and velocity model.
// ----------------------------------------------------------------------------
module force_admittance_velocity_top_test;

   localparam int WIN       = 20;
   localparam int SETTLE    = 400;
   localparam int WDOG_MAX  = 6000;

   typedef struct {
      logic signed [15:0] fx, fy, fz, tz;
      logic [47:0]        rx, ry, rz;
   } sample_type;

   typedef struct {
      logic signed [23:0] vx, vy, vz, wz;
   } velocity_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [fav_pkg::ADDR_W-1:0] csr_addr;
   logic [fav_pkg::DB_W-1:0]   csr_wdata;

   fav_req_if req_if ();
   fav_rsp_if rsp_if ();

   force_admittance_velocity_top #(.WINDOW_LEN(WIN)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   sample_type   pending_samples[$];
   velocity_type expected_vel[$];
   sample_type   in_flight;
   int        errors;
   int        send_gap, recv_stall, idle_cycles;
   bit        no_gaps;

   // model of the window and registers
   logic [fav_pkg::GAIN_W-1:0] alpha_reg, beta_reg;
   logic [fav_pkg::DB_W-1:0]   force_db_reg, torque_db_reg;
   longint win_fx[WIN], win_fy[WIN], win_fz[WIN], win_tz[WIN];
   longint acc_fx, acc_fy, acc_fz, acc_tz;
   int     next_slot, held;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint sat24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic longint rotate(logic [47:0] row, longint mx, longint my, longint mz);
      longint acc;
      acc = longint'($signed(row[15:0])) * mx + longint'($signed(row[31:16])) * my
          + longint'($signed(row[47:32])) * mz;
      return acc >>> 14;   // floor division by 16384
   endfunction

   // add one sample to the window; returns 1 when a velocity comes out
   function automatic bit window_velocity(sample_type s, output velocity_type v);
      longint mx, my, mz, mt, rx, ry, rz, alpha, beta, mag2;
      bit full;
      full = (held >= WIN);
      if (full) begin
         acc_fx -= win_fx[next_slot]; acc_fy -= win_fy[next_slot];
         acc_fz -= win_fz[next_slot]; acc_tz -= win_tz[next_slot];
      end
      win_fx[next_slot] = s.fx; win_fy[next_slot] = s.fy;
      win_fz[next_slot] = s.fz; win_tz[next_slot] = s.tz;
      acc_fx += s.fx; acc_fy += s.fy; acc_fz += s.fz; acc_tz += s.tz;
      next_slot = (next_slot + 1) % WIN;
      if (!full) begin
         held++;
         return 1'b0;
      end
      mx = acc_fx / WIN; my = acc_fy / WIN; mz = acc_fz / WIN; mt = acc_tz / WIN;
      rx = rotate(s.rx, mx, my, mz);
      ry = rotate(s.ry, mx, my, mz);
      rz = rotate(s.rz, mx, my, mz);
      mag2  = rx * rx + ry * ry + rz * rz;
      alpha = (alpha_reg == 0) ? 1 : longint'(alpha_reg);
      beta  = (beta_reg == 0) ? 1 : longint'(beta_reg);
      v.vx = '0; v.vy = '0; v.vz = '0; v.wz = '0;
      if (mag2 > longint'(force_db_reg) * longint'(force_db_reg)) begin
         v.vx = 24'(sat24((rx * 1024) / alpha));
         v.vy = 24'(sat24((ry * 1024) / alpha));
         v.vz = 24'(sat24((rz * 1024) / alpha));
      end
      if ((mt < 0 ? -mt : mt) > longint'(torque_db_reg))
         v.wz = 24'(sat24((-mt * 64) / beta));
      return 1'b1;
   endfunction

   task automatic report(string what, logic signed [23:0] got, logic signed [23:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      logic nv;
      velocity_type v;
      nv = req_if.valid;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            if (window_velocity(in_flight, v)) expected_vel = {expected_vel, v};
            nv = 1'b0;
         end
         if (!nv) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_samples.size() > 0) begin
               in_flight = pending_samples.pop_front();
               req_if.sample_fx <= in_flight.fx;
               req_if.sample_fy <= in_flight.fy;
               req_if.sample_fz <= in_flight.fz;
               req_if.sample_tz <= in_flight.tz;
               req_if.rot_row_x <= in_flight.rx;
               req_if.rot_row_y <= in_flight.ry;
               req_if.rot_row_z <= in_flight.rz;
               nv = 1'b1;
               send_gap = no_gaps ? 0 : $urandom_range(0, 8);
            end
         end
      end
      req_if.valid <= nv;
   end

   // monitor
   always @(posedge clock) begin
      velocity_type want;
      if (reset) begin
         recv_stall = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_vel.size() == 0) begin
               $display("unexpected velocity beat");
               errors++;
            end else begin
               want = expected_vel.pop_front();
               if (rsp_if.vel_x !== want.vx) report("vel_x", rsp_if.vel_x, want.vx);
               if (rsp_if.vel_y !== want.vy) report("vel_y", rsp_if.vel_y, want.vy);
               if (rsp_if.vel_z !== want.vz) report("vel_z", rsp_if.vel_z, want.vz);
               if (rsp_if.spin_z !== want.wz) report("spin_z", rsp_if.spin_z, want.wz);
            end
            recv_stall = no_gaps ? 0 : $urandom_range(0, 8);
         end else if (recv_stall > 0) begin
            recv_stall--;
         end
      end
      rsp_if.ready <= (recv_stall == 0);
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_MAX) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [47:0] make_row(int axis);
      logic [15:0] e[3];
      int mode;
      mode = $urandom_range(0, 3);
      for (int k = 0; k < 3; k++) e[k] = 16'($urandom_range(0, 1200)) - 16'd600;
      if (mode == 0) begin
         return 48'({$urandom, $urandom});
      end else begin
         e[axis] = ($urandom_range(0, 1) == 1) ? 16'sd16384 : -16'sd16384;
         if (mode == 3) e[axis] = 16'($urandom_range(9000, 16384));
         return {e[2], e[1], e[0]};
      end
   endfunction

   function automatic sample_type make_sample(int kind);
      sample_type s;
      if (kind == 0) begin
         s.fx = 16'($urandom); s.fy = 16'($urandom);
         s.fz = 16'($urandom); s.tz = 16'($urandom);
      end else begin
         s.fx = 16'($urandom_range(0, 800)) - 16'd400;
         s.fy = 16'($urandom_range(0, 800)) - 16'd400;
         s.fz = 16'($urandom_range(0, 800)) - 16'd400;
         s.tz = 16'($urandom_range(0, 300)) - 16'd150;
      end
      s.rx = make_row(0); s.ry = make_row(1); s.rz = make_row(2);
      return s;
   endfunction

   task automatic wait_idle();
      while (pending_samples.size() > 0 || req_if.valid || expected_vel.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [fav_pkg::ADDR_W-1:0] idx, logic [fav_pkg::DB_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         fav_pkg::CSR_FORCE_GAIN:  alpha_reg     = value[fav_pkg::GAIN_W-1:0];
         fav_pkg::CSR_TORQUE_GAIN: beta_reg      = value[fav_pkg::GAIN_W-1:0];
         fav_pkg::CSR_FORCE_DB:    force_db_reg  = value;
         fav_pkg::CSR_TORQUE_DB:   torque_db_reg = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_all(logic [fav_pkg::DB_W-1:0] a, logic [fav_pkg::DB_W-1:0] b,
                          logic [fav_pkg::DB_W-1:0] fdb, logic [fav_pkg::DB_W-1:0] tdb);
      write_reg(fav_pkg::CSR_FORCE_GAIN, a);
      write_reg(fav_pkg::CSR_TORQUE_GAIN, b);
      write_reg(fav_pkg::CSR_FORCE_DB, fdb);
      write_reg(fav_pkg::CSR_TORQUE_DB, tdb);
   endtask

   initial begin
      sample_type s;
      no_gaps = 1'b0;
      alpha_reg = 12'd175; beta_reg = 12'd3; force_db_reg = 15'd320; torque_db_reg = 15'd102;
      reset = 1'b1;
      csr_we = 1'b0; csr_addr = '0; csr_wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: fill the window with extremes, then a few emitting beats
      for (int i = 0; i < 24; i++) begin
         s = make_sample(1);
         if (i < 10) begin
            s.fx = 16'sh7FFF; s.fy = 16'sh7FFF; s.fz = 16'sh7FFF; s.tz = 16'sh7FFF;
         end else if (i < 20) begin
            s.fx = 16'sh8000; s.fy = 16'sh8000; s.fz = 16'sh8000; s.tz = 16'sh8000;
         end
         if (i == 20) begin
            s.rx = {16'sh8000, 16'sh8000, 16'sh8000};
            s.ry = {16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
            s.rz = '1;
         end
         pending_samples = {pending_samples, s};
      end
      wait_idle();

      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: set_all(15'd1, 15'd1, 15'd0, 15'd0);
            1: set_all(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
            2: set_all(15'h7000, 15'h7000, 15'd10, 15'd5);     // gain registers read as zero
            3: set_all(15'd175, 15'd3, 15'd320, 15'd102);
            4: ;                                               // no writes, just drained
            default: set_all(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
                             15'($urandom_range(0, 2000)), 15'($urandom_range(0, 600)));
         endcase
         no_gaps = (phase == 3);
         for (int i = 0; i < 48; i++)
            pending_samples = {pending_samples,
                               make_sample($urandom_range(0, 2) == 0 ? 1 : 0)};
         wait_idle();
      end

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
